### hw/rtl/gdfw_pkg.sv
package gdfw_pkg;

  localparam int NODE_COUNT = 16;
  localparam int MAX_DEGREE = 8;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int DEG_W   = $clog2(MAX_DEGREE);
  localparam int CNT_W   = $clog2(MAX_DEGREE + 1);
  localparam int DEPTH_W = $clog2(NODE_COUNT + 1);
  localparam int TBL_W   = NODE_W + DEG_W;
  localparam int TBL_DEPTH = NODE_COUNT * MAX_DEGREE;

  typedef enum logic {
    OP_ADD_EDGE = 1'b0,
    OP_WALK     = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_VISIT  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_FINAL
  } state_t;

  typedef struct packed {
    op_t              operation;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    status_t           status;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic load_edge;
    logic start_walk;
    logic fetch;
    logic pop;
    logic push_emit;
    logic final_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic has_next;
    logic is_new;
    logic last_pop;
  } stat_t;

endpackage

### hw/rtl/gdfw_ctrl.sv
module gdfw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  gdfw_pkg::op_t   in_op,
  input  gdfw_pkg::stat_t stat,
  output logic            in_ready,
  output gdfw_pkg::cmd_t  cmd
);

  gdfw_pkg::state_t state_r;
  gdfw_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdfw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      gdfw_pkg::S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_op == gdfw_pkg::OP_WALK) begin
            cmd.start_walk = 1'b1;
            state_nxt      = gdfw_pkg::S_FETCH;
          end else begin
            cmd.load_edge = 1'b1;
          end
        end
      end
      gdfw_pkg::S_FETCH: begin
        if (stat.has_next) begin
          cmd.fetch = 1'b1;
          state_nxt = gdfw_pkg::S_CHECK;
        end else begin
          cmd.pop = 1'b1;
          if (stat.last_pop) begin
            state_nxt = gdfw_pkg::S_FINAL;
          end
        end
      end
      gdfw_pkg::S_CHECK: begin
        if (!stat.is_new) begin
          state_nxt = gdfw_pkg::S_FETCH;
        end else if (stat.out_free) begin
          cmd.push_emit = 1'b1;
          state_nxt     = gdfw_pkg::S_FETCH;
        end
      end
      gdfw_pkg::S_FINAL: begin
        if (stat.out_free) begin
          cmd.final_emit = 1'b1;
          state_nxt      = gdfw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gdfw_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/gdfw_dp.sv
module gdfw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gdfw_pkg::cmd_t      cmd,
  input  gdfw_pkg::in_item_t  in_item,
  input  logic                out_stall,
  output gdfw_pkg::stat_t     stat,
  output logic                out_valid,
  output gdfw_pkg::out_item_t out_item
);

  logic [gdfw_pkg::NODE_W-1:0]  table_mem [gdfw_pkg::TBL_DEPTH];
  logic [gdfw_pkg::NODE_W-1:0]  rd_r;
  logic [gdfw_pkg::CNT_W-1:0]   count_r [gdfw_pkg::NODE_COUNT];
  logic [gdfw_pkg::NODE_COUNT-1:0] visited_r;
  logic [gdfw_pkg::NODE_COUNT-1:0] visited_nxt;
  logic [gdfw_pkg::NODE_W-1:0]  stk_node_r [gdfw_pkg::NODE_COUNT];
  logic [gdfw_pkg::CNT_W-1:0]   stk_next_r [gdfw_pkg::NODE_COUNT];
  logic [gdfw_pkg::DEPTH_W-1:0] depth_r;
  logic [gdfw_pkg::DEPTH_W-1:0] depth_nxt;
  logic [gdfw_pkg::NODE_W-1:0]  pend_r;
  logic                         out_valid_r;
  gdfw_pkg::out_item_t          out_item_r;

  logic [gdfw_pkg::NODE_W-1:0] top;
  logic [gdfw_pkg::NODE_W-1:0] cur;
  logic [gdfw_pkg::CNT_W-1:0]  idx;
  logic [gdfw_pkg::CNT_W-1:0]  src_cnt;
  logic                        edge_ok;

  assign top     = gdfw_pkg::NODE_W'(depth_r - gdfw_pkg::DEPTH_W'(1));
  assign cur     = stk_node_r[top];
  assign idx     = stk_next_r[top];
  assign src_cnt = count_r[in_item.from_node];
  assign edge_ok = src_cnt < gdfw_pkg::CNT_W'(gdfw_pkg::MAX_DEGREE);

  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.has_next = idx < count_r[cur];
  assign stat.is_new   = !visited_r[rd_r] &&
                         (depth_r < gdfw_pkg::DEPTH_W'(gdfw_pkg::NODE_COUNT));
  assign stat.last_pop = depth_r == gdfw_pkg::DEPTH_W'(1);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (cmd.load_edge && edge_ok) begin
      table_mem[{in_item.from_node, src_cnt[gdfw_pkg::DEG_W-1:0]}] <= in_item.to_node;
    end
    if (cmd.fetch) begin
      rd_r <= table_mem[{cur, idx[gdfw_pkg::DEG_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gdfw_pkg::NODE_COUNT; i++) begin
        count_r[i] <= '0;
      end
    end else if (cmd.load_edge && edge_ok) begin
      count_r[in_item.from_node] <= src_cnt + gdfw_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    visited_nxt = visited_r;
    depth_nxt   = depth_r;
    if (cmd.start_walk) begin
      visited_nxt                    = '0;
      visited_nxt[in_item.from_node] = 1'b1;
      depth_nxt                      = gdfw_pkg::DEPTH_W'(1);
    end else if (cmd.push_emit) begin
      visited_nxt[rd_r] = 1'b1;
      depth_nxt         = depth_r + gdfw_pkg::DEPTH_W'(1);
    end else if (cmd.pop) begin
      depth_nxt = depth_r - gdfw_pkg::DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      depth_r   <= '0;
    end else begin
      visited_r <= visited_nxt;
      depth_r   <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      stk_node_r[0] <= in_item.from_node;
      stk_next_r[0] <= '0;
      pend_r        <= in_item.from_node;
    end else if (cmd.push_emit) begin
      stk_node_r[depth_r[gdfw_pkg::NODE_W-1:0]] <= rd_r;
      stk_next_r[depth_r[gdfw_pkg::NODE_W-1:0]] <= '0;
      pend_r                                    <= rd_r;
    end else if (cmd.fetch) begin
      stk_next_r[top] <= idx + gdfw_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_edge || cmd.push_emit || cmd.final_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      out_item_r.node   <= '0;
      out_item_r.status <= edge_ok ? gdfw_pkg::ST_ACCEPT : gdfw_pkg::ST_REJECT;
      out_item_r.last   <= 1'b1;
    end else if (cmd.push_emit || cmd.final_emit) begin
      out_item_r.node   <= pend_r;
      out_item_r.status <= gdfw_pkg::ST_VISIT;
      out_item_r.last   <= cmd.final_emit;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_edge || cmd.push_emit || cmd.final_emit) |-> (!out_valid_r || !out_stall))
    else $error("Result loaded while the output register is held.");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_emit |-> (depth_r < gdfw_pkg::DEPTH_W'(gdfw_pkg::NODE_COUNT)))
    else $error("Push onto a full walk stack.");

  a_final_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.final_emit |-> (depth_r == '0))
    else $error("Walk finished with entries left on the stack.");

  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_walk |=> ($countones(visited_r) == 1 && depth_r == gdfw_pkg::DEPTH_W'(1)))
    else $error("Walk did not start from a single visited node.");

endmodule

### hw/rtl/graph_depth_first_walk.sv
// Depth-first walk over a directed graph of 16 nodes, at most 8 targets per node.
// The input channel (in_valid, in_stall, in_item) takes one item at a time. An
// add-edge item appends to_node to the list of from_node and yields one result
// with status accepted or rejected (list full) and last set. A walk item yields
// every node reachable from from_node once, in preorder, neighbours tried in the
// order they were added; the final node of the walk carries last.
// The result channel (out_valid, out_stall, out_item) has one output register.
// An add-edge result is registered; the next item can be taken in the following
// cycle unless out_stall holds that result. During a walk, each list entry
// examined needs a table read and a check, and each node visited is popped once.
// The walk loop is bound by the single read port of the neighbour table.
// in_stall is high while a walk runs and while a finished result is held by
// out_stall; the walk pauses at each new node until the output register frees.
// Synchronous reset empties every list, the walk stack and the output register.
module graph_depth_first_walk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdfw_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gdfw_pkg::out_item_t out_item
);

  gdfw_pkg::cmd_t  cmd;
  gdfw_pkg::stat_t stat;
  logic            in_ready;

  assign in_stall = !in_ready;

  gdfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.operation),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  gdfw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
